// ===== rtl/ipid_pkg.sv =====
// Package for the incremental PID controller: beat types, register indexes and codes.
package ipid_pkg;

  localparam int DATA_W = 24;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_OMAX = 3'd3,
    REG_OMIN = 3'd4
  } cfg_reg_t;

  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [1:0] CLIP_NONE = 2'd0;
  localparam logic [1:0] CLIP_HIGH = 2'd1;
  localparam logic [1:0] CLIP_LOW  = 2'd2;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] feedback;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic [1:0]               clip;
    logic                     result_kind;
  } out_beat_t;

endpackage

// ===== rtl/incremental_pid_controller_unit.sv =====
// Velocity-form PID controller: input register, combinational update, result register.
// An accepted beat goes into the input register, its result then into the result register.
// Throughput: one item per cycle while out_ready allows; the state loop (output and error
// history) closes in the single compute stage between the input and result registers.
// Reset: gains and clamps return to kp = 1.0, ki = kd = 0, full-scale limits; history is zero.
// Config writes are always accepted and take effect on the next compute item.
module incremental_pid_controller_unit #(
  parameter int FRAC_BITS = 12,
  parameter int ACC_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ipid_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ipid_pkg::out_beat_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ipid_pkg::IDX_W-1:0]        cfg_index,
  input  logic [ipid_pkg::DATA_W-1:0]       cfg_data
);
  import ipid_pkg::*;

  localparam int CW   = DATA_W + 3;
  localparam int PW   = CW + DATA_W;
  localparam int SW   = (PW > 62) ? PW : 62;
  localparam int SUMW = ((SW > ACC_WIDTH) ? SW : ACC_WIDTH) + 2;
  localparam int CMW  = (ACC_WIDTH > DATA_W) ? ACC_WIDTH : DATA_W;

  localparam logic signed [SW-1:0]   TERM_HI = {{(SW-61){1'b0}}, 1'b1, 60'b0};
  localparam logic signed [SW-1:0]   TERM_LO = -TERM_HI;
  localparam logic signed [SUMW-1:0] ACC_HI  =
    {{(SUMW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] ACC_LO  = ~ACC_HI;
  localparam logic signed [DATA_W-1:0] D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] D_MIN = ~D_MAX;

  // config registers
  logic signed [DATA_W-1:0] kp_r, ki_r, kd_r, omax_r, omin_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= DATA_W'(1) << FRAC_BITS;
      ki_r   <= '0;
      kd_r   <= '0;
      omax_r <= D_MAX;
      omin_r <= D_MIN;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_KP:   kp_r   <= cfg_data;
        REG_KI:   ki_r   <= cfg_data;
        REG_KD:   kd_r   <= cfg_data;
        REG_OMAX: omax_r <= cfg_data;
        REG_OMIN: omin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: error is formed and saturated here
  logic                     s1_valid_r;
  logic                     s1_clear_r;
  logic signed [DATA_W-1:0] s1_err_r;
  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W-1:0] err_sat;
  logic                     s1_adv;
  logic                     in_fire;

  assign s1_adv   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    diff = (DATA_W+1)'(in_data.setpoint) - (DATA_W+1)'(in_data.feedback);
    if (diff[DATA_W] != diff[DATA_W-1]) begin
      err_sat = diff[DATA_W] ? D_MIN : D_MAX;
    end else begin
      err_sat = diff[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_clear_r <= (in_data.req_type == REQ_CLEAR);
      s1_err_r   <= err_sat;
    end
  end

  // compute stage
  logic signed [DATA_W-1:0]    last_err_r, older_err_r;
  logic signed [ACC_WIDTH-1:0] last_out_r;
  logic signed [CW-1:0]        coef [3];
  logic signed [DATA_W-1:0]    ehist [3];
  logic signed [PW-1:0]        prod [3];
  logic signed [SW-1:0]        term [3];
  logic signed [SW-1:0]        shifted;
  logic signed [SUMW-1:0]      sum;
  logic signed [ACC_WIDTH-1:0] acc_nxt;
  logic signed [CMW-1:0]       acc_c, omax_c, omin_c;
  out_beat_t                   res_nxt;

  always_comb begin
    coef[0]  = CW'(kp_r) + CW'(ki_r) + CW'(kd_r);
    coef[1]  = -CW'(kp_r) - (CW'(kd_r) <<< 1);
    coef[2]  = CW'(kd_r);
    ehist[0] = s1_err_r;
    ehist[1] = last_err_r;
    ehist[2] = older_err_r;
    shifted  = '0;
    for (int i = 0; i < 3; i++) begin
      prod[i] = coef[i] * ehist[i];
      shifted = SW'(prod[i]) >>> FRAC_BITS;
      if (shifted > TERM_HI) begin
        term[i] = TERM_HI;
      end else if (shifted < TERM_LO) begin
        term[i] = TERM_LO;
      end else begin
        term[i] = shifted;
      end
    end
    sum = SUMW'(last_out_r) + SUMW'(term[0]) + SUMW'(term[1]) + SUMW'(term[2]);
    if (sum > ACC_HI) begin
      acc_nxt = ACC_HI[ACC_WIDTH-1:0];
    end else if (sum < ACC_LO) begin
      acc_nxt = ACC_LO[ACC_WIDTH-1:0];
    end else begin
      acc_nxt = sum[ACC_WIDTH-1:0];
    end

    acc_c  = CMW'(acc_nxt);
    omax_c = CMW'(omax_r);
    omin_c = CMW'(omin_r);
    res_nxt.result_kind = KIND_STEP;
    if (acc_c > omax_c) begin
      res_nxt.drive = omax_r;
      res_nxt.clip  = CLIP_HIGH;
    end else if (acc_c < omin_c) begin
      res_nxt.drive = omin_r;
      res_nxt.clip  = CLIP_LOW;
    end else begin
      res_nxt.drive = acc_c[DATA_W-1:0];
      res_nxt.clip  = CLIP_NONE;
    end
    if (s1_clear_r) begin
      res_nxt.drive       = '0;
      res_nxt.clip        = CLIP_NONE;
      res_nxt.result_kind = KIND_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r  <= '0;
      older_err_r <= '0;
      last_out_r  <= '0;
    end else if (s1_adv) begin
      if (s1_clear_r) begin
        last_err_r  <= '0;
        older_err_r <= '0;
        last_out_r  <= '0;
      end else begin
        last_err_r  <= s1_err_r;
        older_err_r <= last_err_r;
        last_out_r  <= acc_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= res_nxt;
    end
  end

endmodule

// ===== test/tb.sv =====
// Self-checking bench for the velocity-form PID unit: streams steps and clears, checks each drive beat.
module tb;
  import ipid_pkg::*;

  localparam int FRAC = 12;
  localparam int ACC_W = 32;
  localparam int ONE_Q = 1 << FRAC;
  localparam longint TERM_CAP = longint'(1) << 60;
  localparam logic signed [DATA_W-1:0] TOP_VAL = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] BOTTOM_VAL = {1'b1, {(DATA_W - 1){1'b0}}};
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT = 1000;

  class pid_scoreboard;
    longint kp, ki, kd, hi_limit, lo_limit;
    longint err_1, err_2, out_acc;
    out_beat_t pending_drives[$];
    int errors, checked, requests, clears, clipped_hi, clipped_lo, reg_writes;

    function new();
      kp = longint'(1) << FRAC;
      ki = 0;
      kd = 0;
      hi_limit = (longint'(1) << (DATA_W - 1)) - 1;
      lo_limit = -hi_limit - 1;
      err_1 = 0;
      err_2 = 0;
      out_acc = 0;
      errors = 0;
      checked = 0;
      requests = 0;
      clears = 0;
      clipped_hi = 0;
      clipped_lo = 0;
      reg_writes = 0;
    endfunction

    function longint saturate(longint x, int w);
      longint top;
      top = (longint'(1) << (w - 1)) - 1;
      if (x > top) return top;
      if (x < -top - 1) return -top - 1;
      return x;
    endfunction

    // floor of the Q12.12 product, magnitude capped
    function longint scaled_product(longint c, longint e);
      longint p;
      p = (c * e) >>> FRAC;
      if (p > TERM_CAP) p = TERM_CAP;
      if (p < -TERM_CAP) p = -TERM_CAP;
      return p;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      reg_writes++;
      case (idx)
        REG_KP:   kp = longint'($signed(val));
        REG_KI:   ki = longint'($signed(val));
        REG_KD:   kd = longint'($signed(val));
        REG_OMAX: hi_limit = longint'($signed(val));
        REG_OMIN: lo_limit = longint'($signed(val));
        default: ;
      endcase
    endfunction

    function void note_request(in_beat_t req);
      out_beat_t want;
      longint err, acc;
      want = '0;
      requests++;
      if (req.req_type == REQ_CLEAR) begin
        err_1 = 0;
        err_2 = 0;
        out_acc = 0;
        clears++;
        want.result_kind = KIND_CLEAR;
        want.clip = CLIP_NONE;
      end else begin
        err = saturate(longint'(req.setpoint) - longint'(req.feedback), DATA_W);
        acc = out_acc + scaled_product(kp + ki + kd, err)
            + scaled_product(-kp - 2 * kd, err_1) + scaled_product(kd, err_2);
        out_acc = saturate(acc, ACC_W);
        err_2 = err_1;
        err_1 = err;
        want.result_kind = KIND_STEP;
        // high test first, so inverted limits favor out_max
        if (out_acc > hi_limit) begin
          want.drive = DATA_W'(hi_limit);
          want.clip = CLIP_HIGH;
          clipped_hi++;
        end else if (out_acc < lo_limit) begin
          want.drive = DATA_W'(lo_limit);
          want.clip = CLIP_LOW;
          clipped_lo++;
        end else begin
          want.drive = DATA_W'(out_acc);
          want.clip = CLIP_NONE;
        end
      end
      pending_drives.push_back(want);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      checked++;
      if (pending_drives.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got drive %0d clip %0d kind %0d",
                 $time, got.drive, got.clip, got.result_kind);
        return;
      end
      want = pending_drives.pop_front();
      if (got.drive !== want.drive) begin
        errors++;
        $display("%0t: drive expected %0d, got %0d", $time, want.drive, got.drive);
      end
      if (got.clip !== want.clip) begin
        errors++;
        $display("%0t: clip expected %0d, got %0d", $time, want.clip, got.clip);
      end
      if (got.result_kind !== want.result_kind) begin
        errors++;
        $display("%0t: result_kind expected %0d, got %0d", $time, want.result_kind,
                 got.result_kind);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  out_beat_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  pid_scoreboard sb;
  int tx_idle_pct = 30;
  int rx_idle_pct = 30;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;
  int setups = 0;

  incremental_pid_controller_unit #(
    .FRAC_BITS(FRAC),
    .ACC_WIDTH(ACC_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
    if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // result side; a hold request parks out_ready low so the pipe backs up
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send(logic kind, logic signed [DATA_W-1:0] sp, fb);
    in_beat_t b;
    b.req_type = kind;
    b.setpoint = sp;
    b.feedback = fb;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_drives.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic reconfigure(logic signed [DATA_W-1:0] kp, ki, kd, omax, omin);
    settle();
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_OMAX, omax);
    write_reg(REG_OMIN, omin);
    // spare indexes must leave everything alone
    for (int i = int'(REG_OMIN) + 1; i < (1 << IDX_W); i++)
      write_reg(IDX_W'(i), DATA_W'($urandom));
    setups++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_gain(int style);
    longint v;
    case (style)
      0: begin
        v = longint'(int'($urandom_range(0, 8 * ONE_Q))) - 4 * ONE_Q;
        return DATA_W'(v);
      end
      1: return DATA_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return TOP_VAL;
          1: return BOTTOM_VAL;
          2: return '0;
          default: return DATA_W'(ONE_Q);
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_level();
    longint v;
    case ($urandom_range(0, 9))
      0: return TOP_VAL;
      1: return BOTTOM_VAL;
      2: return '0;
      3, 4, 5: begin
        v = longint'(int'($urandom_range(0, 32 * ONE_Q))) - 16 * ONE_Q;
        return DATA_W'(v);
      end
      default: return DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    int style;
    int r;
    longint jitter;
    logic signed [DATA_W-1:0] lim_a, lim_b, omax, omin, sp, fb;

    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_KP;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset gains: kp = 1.0, full-scale limits
    send(REQ_STEP, '0, '0);
    send(REQ_STEP, TOP_VAL, BOTTOM_VAL);
    send(REQ_STEP, BOTTOM_VAL, TOP_VAL);
    send(REQ_STEP, DATA_W'(1), '0);
    send(REQ_STEP, DATA_W'(-1), '0);
    send(REQ_CLEAR, DATA_W'($urandom), DATA_W'($urandom));
    send(REQ_STEP, DATA_W'(ONE_Q), DATA_W'(-ONE_Q));

    // largest gains drive the accumulator into saturation
    reconfigure(TOP_VAL, TOP_VAL, TOP_VAL, TOP_VAL, BOTTOM_VAL);
    send(REQ_STEP, TOP_VAL, BOTTOM_VAL);
    send(REQ_STEP, TOP_VAL, BOTTOM_VAL);
    send(REQ_STEP, BOTTOM_VAL, TOP_VAL);
    send(REQ_STEP, BOTTOM_VAL, TOP_VAL);
    send(REQ_CLEAR, TOP_VAL, BOTTOM_VAL);

    // most negative gains, zero-width output window
    reconfigure(BOTTOM_VAL, BOTTOM_VAL, BOTTOM_VAL, '0, '0);
    send(REQ_STEP, TOP_VAL, '0);
    send(REQ_STEP, '0, TOP_VAL);
    send(REQ_STEP, '0, '0);

    // inverted window: out_min above out_max
    reconfigure(DATA_W'(ONE_Q), DATA_W'(ONE_Q / 2), DATA_W'(ONE_Q / 4),
                DATA_W'(-10 * ONE_Q), DATA_W'(10 * ONE_Q));
    send(REQ_STEP, '0, '0);
    send(REQ_STEP, DATA_W'(-50 * ONE_Q), '0);
    send(REQ_STEP, DATA_W'(50 * ONE_Q), '0);
    send(REQ_CLEAR, '0, '0);
    send(REQ_STEP, DATA_W'(12 * ONE_Q), DATA_W'(ONE_Q));

    for (int p = 0; p < PHASES; p++) begin
      style = p % 3;
      lim_a = pick_level();
      lim_b = pick_level();
      if (p % 4 == 3) begin
        omax = TOP_VAL;
        omin = BOTTOM_VAL;
      end else if ((p % 4 == 2) == (lim_a > lim_b)) begin
        omax = lim_b;
        omin = lim_a;
      end else begin
        omax = lim_a;
        omin = lim_b;
      end
      reconfigure(pick_gain(style), pick_gain(style), pick_gain(style), omax, omin);
      tx_idle_pct = (p == 4) ? 0 : 30;
      rx_idle_pct = (p == 4) ? 0 : 30;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 40) hold_request = 1'b1;
        sp = pick_level();
        r = $urandom_range(0, 99);
        if (r < 45) begin
          jitter = longint'(int'($urandom_range(0, 2 * ONE_Q))) - ONE_Q;
          fb = DATA_W'(longint'(sp) + jitter);
        end else begin
          fb = pick_level();
        end
        send((r >= 95) ? REQ_CLEAR : REQ_STEP, sp, fb);
      end
    end

    settle();
    $display("covered %0d requests (%0d history clears) over %0d gain/limit setups",
             sb.requests, sb.clears, setups + 1);
    $display("checked %0d beats after %0d reg writes, %0d clamped high, %0d clamped low",
             sb.checked, sb.reg_writes, sb.clipped_hi, sb.clipped_lo);
    if (sb.errors == 0 && sb.pending_drives.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
